// ===== hw/rtl/keyboard_rollover_report_builder_core_defines.svh =====
// Assertion macros for the key rollover report builder.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef KEYBOARD_ROLLOVER_REPORT_BUILDER_CORE_DEFINES_SVH
`define KEYBOARD_ROLLOVER_REPORT_BUILDER_CORE_DEFINES_SVH

// Check cons in the same cycle as ante.
`define KRRB_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rollover report builder check failed");

// Check cons in the cycle after ante.
`define KRRB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rollover report builder check failed");

`endif

// ===== hw/rtl/krrb_pkg.sv =====
// Shared types and constants for the key rollover report builder.
// No dependencies.
package krrb_pkg;

  localparam int unsigned CodeW    = 8;
  localparam int unsigned OutSlots = 6;

  typedef logic [CodeW-1:0] code_t;

  typedef struct packed {
    logic                       changed;
    code_t [OutSlots-1:0]       slots;
  } report_t;

endpackage

// ===== hw/rtl/keyboard_rollover_report_builder_core.sv =====
// Key rollover report builder: collects scanned keys into report slots.
// Depends on krrb_pkg and keyboard_rollover_report_builder_core_defines.svh.
//
// One scanned key is taken every clock cycle while the skid register is
// empty. Each key updates the slot array in the cycle it is accepted; the
// key marked tlast closes the scan and its report is registered into the
// output register, or into the single skid register if the output is full.
// The slave side stalls only while both hold untaken reports. empty_code is
// written through the cfg channel, which is always ready.
`include "keyboard_rollover_report_builder_core_defines.svh"

module keyboard_rollover_report_builder_core
  import krrb_pkg::*;
#(
  parameter int unsigned SLOT_COUNT = 6
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,

  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [CodeW-1:0]          cfg_data_i,     // empty_code

  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [CodeW-1:0]          s_axis_tdata,   // key_code
  input  logic                      s_axis_tuser,   // key_pressed
  input  logic                      s_axis_tlast,   // last_key

  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [OutSlots*CodeW-1:0] m_axis_tdata,   // slot_zero .. slot_five
  output logic                      m_axis_tuser    // report_changed
);

  localparam int unsigned FillW = $clog2(SLOT_COUNT + 1);
  localparam int unsigned PadN  = (SLOT_COUNT > OutSlots) ? SLOT_COUNT : OutSlots;

  code_t             empty_q;
  code_t             slots_q [SLOT_COUNT];
  logic [FillW-1:0]  fill_q;
  logic              changed_q;

  code_t             slots_upd [SLOT_COUNT];
  code_t             slots_fin [SLOT_COUNT];
  code_t             slots_pad [PadN];
  logic [FillW-1:0]  fill_upd;
  logic              changed_upd;
  logic              full;
  report_t           res;

  report_t           main_q;
  report_t           skid_q;
  logic              main_valid_q;
  logic              skid_valid_q;

  logic              in_fire;
  logic              out_fire;
  logic              res_fire;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !skid_valid_q;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign res_fire      = in_fire && s_axis_tlast;
  assign out_fire      = main_valid_q && m_axis_tready;

  assign m_axis_tvalid = main_valid_q;
  assign m_axis_tdata  = main_q.slots;
  assign m_axis_tuser  = main_q.changed;

  assign full = (fill_q == FillW'(SLOT_COUNT));

  always_comb begin
    slots_upd   = slots_q;
    changed_upd = changed_q;
    fill_upd    = fill_q;
    if (!full) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        if (fill_q == FillW'(i)) begin
          if (s_axis_tuser) begin
            if (slots_q[i] != s_axis_tdata) begin
              slots_upd[i] = s_axis_tdata;
              changed_upd  = 1'b1;
            end
          end else if (slots_q[i] == s_axis_tdata) begin
            slots_upd[i] = empty_q;
            changed_upd  = 1'b1;
          end
        end
      end
      if (s_axis_tuser) begin
        fill_upd = fill_q + FillW'(1);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      slots_fin[i] = (FillW'(i) >= fill_upd) ? empty_q : slots_upd[i];
    end
    for (int i = 0; i < PadN; i++) begin
      slots_pad[i] = '0;
    end
    for (int i = 0; i < SLOT_COUNT; i++) begin
      slots_pad[i] = slots_fin[i];
    end
    for (int i = 0; i < OutSlots; i++) begin
      res.slots[i] = slots_pad[i];
    end
    res.changed = changed_upd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      empty_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      empty_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slots_q[i] <= '0;
      end
      fill_q    <= '0;
      changed_q <= 1'b0;
    end else if (in_fire) begin
      if (s_axis_tlast) begin
        slots_q   <= slots_fin;
        fill_q    <= '0;
        changed_q <= 1'b0;
      end else begin
        slots_q   <= slots_upd;
        fill_q    <= fill_upd;
        changed_q <= changed_upd;
      end
    end
  end

  // Hold reports: main register drives the port, skid catches one more.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_fire) begin
        skid_valid_q <= 1'b0;
      end
    end else if (res_fire) begin
      if (!main_valid_q || out_fire) begin
        main_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_fire) begin
      main_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) begin
        main_q <= skid_q;
      end
    end else if (res_fire) begin
      if (!main_valid_q || out_fire) begin
        main_q <= res;
      end else begin
        skid_q <= res;
      end
    end
  end

  `KRRB_ASSERT_NOW(skid_implies_main, skid_valid_q, main_valid_q)
  `KRRB_ASSERT_NOW(fill_in_range, 1'b1, fill_q <= FillW'(SLOT_COUNT))
  `KRRB_ASSERT_NEXT(last_key_clears_scan, res_fire, fill_q == '0 && !changed_q)
  `KRRB_ASSERT_NEXT(last_key_gives_report, res_fire, main_valid_q)

endmodule

// ===== tb/tb_keyboard_rollover_report_builder_core.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for keyboard_rollover_report_builder_core.
// Drives key scans and empty_code writes, and predicts reports with a scoreboard.
// Depends on krrb_pkg and the core RTL only.

module tb_keyboard_rollover_report_builder_core;
  import krrb_pkg::*;

  localparam int unsigned SlotCount = 6;
  localparam int unsigned Phases    = 6;
  localparam int unsigned PhaseKeys = 84;

  typedef enum logic [1:0] {
    SinkOpen,
    SinkCoin,
    SinkSparse,
    SinkComb
  } sink_mode_e;

  class rollover_scoreboard;
    code_t       slots [SlotCount];
    int unsigned fill;
    bit          changed;
    code_t       blank_code;
    report_t     reports_due [$];
    int unsigned errors;

    function new();
      foreach (slots[i]) slots[i] = '0;
      fill       = 0;
      changed    = 1'b0;
      blank_code = '0;
      errors     = 0;
    endfunction

    function void set_blank(code_t code);
      blank_code = code;
    endfunction

    function bit is_full();
      return fill >= SlotCount;
    endfunction

    function code_t slot_at_fill();
      return is_full() ? slots[0] : slots[fill];
    endfunction

    // Note one accepted key and queue the report it closes.
    function void take_key(logic pressed, code_t code, logic last);
      report_t rpt;
      if (fill < SlotCount) begin
        if (pressed) begin
          if (slots[fill] != code) begin
            slots[fill] = code;
            changed     = 1'b1;
          end
          fill++;
        end else if (slots[fill] == code) begin
          slots[fill] = blank_code;
          changed     = 1'b1;
        end
      end
      if (last) begin
        for (int i = fill; i < SlotCount; i++) slots[i] = blank_code;
        rpt.changed = changed;
        for (int i = 0; i < OutSlots; i++) rpt.slots[i] = (i < SlotCount) ? slots[i] : '0;
        reports_due.push_back(rpt);
        fill    = 0;
        changed = 1'b0;
      end
    endfunction

    task note_mismatch(string field, logic [CodeW-1:0] got, logic [CodeW-1:0] want);
      $display("ERROR @%0t: %s got %h want %h", $realtime, field, got, want);
      errors++;
    endtask

    task check_report(logic [OutSlots*CodeW-1:0] data, logic user);
      report_t want;
      if (reports_due.size() == 0) begin
        note_mismatch("report pending", {{(CodeW-1){1'b0}}, 1'b1}, '0);
      end else begin
        want = reports_due.pop_front();
        for (int i = 0; i < OutSlots; i++) begin
          if (data[i*CodeW +: CodeW] !== want.slots[i])
            note_mismatch($sformatf("slot %0d", i), data[i*CodeW +: CodeW], want.slots[i]);
        end
        if (user !== want.changed)
          note_mismatch("report_changed", {{(CodeW-1){1'b0}}, user},
                        {{(CodeW-1){1'b0}}, want.changed});
      end
    endtask
  endclass

  logic                      clk_i;
  logic                      rst_ni;
  logic                      cfg_valid_i;
  logic                      cfg_ready_o;
  logic [CodeW-1:0]          cfg_data_i;
  logic                      s_axis_tvalid;
  logic                      s_axis_tready;
  logic [CodeW-1:0]          s_axis_tdata;
  logic                      s_axis_tuser;
  logic                      s_axis_tlast;
  logic                      m_axis_tvalid;
  logic                      m_axis_tready;
  logic [OutSlots*CodeW-1:0] m_axis_tdata;
  logic                      m_axis_tuser;

  rollover_scoreboard report_sb = new();
  int unsigned        burst_left;

  keyboard_rollover_report_builder_core #(
    .SLOT_COUNT(SlotCount)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) report_sb.check_report(m_axis_tdata, m_axis_tuser);
      if (cfg_valid_i && cfg_ready_o) report_sb.set_blank(cfg_data_i);
      if (s_axis_tvalid && s_axis_tready)
        report_sb.take_key(s_axis_tuser, s_axis_tdata, s_axis_tlast);
    end
  end

  // Stall the master side on a changing pattern.
  initial begin
    sink_mode_e  mode;
    int unsigned span;
    int unsigned tick;
    m_axis_tready = 1'b0;
    tick          = 0;
    forever begin
      mode = sink_mode_e'($urandom_range(0, 3));
      span = $urandom_range(20, 200);
      repeat (span) begin
        @(negedge clk_i);
        tick++;
        case (mode)
          SinkOpen:   m_axis_tready = 1'b1;
          SinkCoin:   m_axis_tready = 1'($urandom_range(0, 1));
          SinkSparse: m_axis_tready = ($urandom_range(0, 3) == 0);
          default:    m_axis_tready = ((tick % 5) < 2);
        endcase
      end
    end
  end

  task automatic send_key(logic pressed, code_t code, logic last);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 8);
      repeat (gap) begin
        @(negedge clk_i);
        s_axis_tvalid = 1'b0;
      end
      burst_left = ($urandom_range(0, 5) == 0) ? 100 : $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = pressed;
    s_axis_tdata  = code;
    s_axis_tlast  = last;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (report_sb.reports_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_blank(code_t code);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i  = code;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Send whole scans; keys past a full report are not counted.
  task automatic random_scans(int unsigned count);
    int unsigned taken;
    int unsigned len;
    logic        pressed;
    code_t       code;
    taken = 0;
    while (taken < count) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 14) : $urandom_range(1, 7);
      for (int k = 0; k < len; k++) begin
        pressed = ($urandom_range(0, 3) != 0);
        case ($urandom_range(0, 9))
          0, 1, 2: code = report_sb.slot_at_fill();
          3:       code = report_sb.blank_code;
          4:       code = ($urandom_range(0, 1) == 0) ? 8'h00 : 8'hFF;
          default: code = code_t'($urandom_range(0, 255));
        endcase
        if (!report_sb.is_full()) taken++;
        send_key(pressed, code, (k == len - 1));
      end
    end
  endtask

  initial begin
    code_t blank_steps [Phases];
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    s_axis_tlast  = 1'b0;
    burst_left    = 0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // same code as the reset content, closed at once
    send_key(1'b1, 8'h00, 1'b1);
    // release of an empty slot, unmatched release, overfill and ignored keys
    send_key(1'b1, 8'hFF, 1'b0);
    send_key(1'b0, 8'h00, 1'b0);
    send_key(1'b1, 8'h04, 1'b0);
    send_key(1'b0, 8'h12, 1'b0);
    send_key(1'b1, 8'h04, 1'b0);
    send_key(1'b1, 8'h05, 1'b0);
    send_key(1'b1, 8'h06, 1'b0);
    send_key(1'b1, 8'h07, 1'b0);
    send_key(1'b1, 8'h08, 1'b0);
    send_key(1'b0, 8'h07, 1'b1);
    // repeat the full scan: nothing changes
    send_key(1'b1, 8'hFF, 1'b0);
    send_key(1'b1, 8'h04, 1'b0);
    send_key(1'b1, 8'h04, 1'b0);
    send_key(1'b1, 8'h05, 1'b0);
    send_key(1'b1, 8'h06, 1'b0);
    send_key(1'b1, 8'h07, 1'b1);
    send_key(1'b0, 8'hFF, 1'b1);
    send_key(1'b0, 8'h00, 1'b1);

    blank_steps[0] = 8'hFF;
    blank_steps[1] = 8'h00;
    blank_steps[2] = 8'h5A;
    blank_steps[3] = code_t'($urandom_range(0, 255));
    blank_steps[4] = 8'h80;
    blank_steps[5] = code_t'($urandom_range(0, 255));
    for (int p = 0; p < Phases; p++) begin
      drain();
      write_blank(blank_steps[p]);
      random_scans(PhaseKeys);
    end

    drain();
    repeat (8) @(posedge clk_i);
    if (report_sb.errors == 0 && report_sb.reports_due.size() == 0) begin
      $display("keyboard_rollover_report_builder_core: match");
    end else begin
      $display("keyboard_rollover_report_builder_core: mismatch");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("keyboard_rollover_report_builder_core: mismatch");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/krrb_pkg.sv
hw/rtl/keyboard_rollover_report_builder_core.sv
tb/tb_keyboard_rollover_report_builder_core.sv
